[hdl/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types, byte codes and helpers of the telnet stream endpoint.
// ----------------------------------------------------------------------------
package tse_pkg;

	localparam int OPTION_COUNT = 256;
	localparam int TABLE_DEPTH  = 2 * OPTION_COUNT;
	localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

	localparam logic [7:0] B_IAC      = 8'hFF;
	localparam logic [7:0] B_CR       = 8'h0D;
	localparam logic [7:0] B_LF       = 8'h0A;
	localparam logic [7:0] B_NUL      = 8'h00;
	localparam logic [7:0] C_SE       = 8'd240;
	localparam logic [7:0] C_CMD_LO   = 8'd241;
	localparam logic [7:0] C_CMD_HI   = 8'd249;
	localparam logic [7:0] C_SB       = 8'd250;
	localparam logic [7:0] C_WILL     = 8'd251;
	localparam logic [7:0] C_WONT     = 8'd252;
	localparam logic [7:0] C_DO       = 8'd253;
	localparam logic [7:0] C_DONT     = 8'd254;

	localparam logic [1:0] WANT_WANTED   = 2'd1;
	localparam logic [1:0] WANT_ACCEPTED = 2'd2;
	localparam logic [1:0] POLICY_BAD    = 2'd3;
	localparam logic [1:0] RS_SENT       = 2'd1;
	localparam logic [1:0] RS_ACK        = 2'd2;

	typedef enum logic [1:0] {
		IK_RX     = 2'd0,
		IK_TX     = 2'd1,
		IK_LREQ   = 2'd2,
		IK_POLICY = 2'd3
	} in_kind_t;

	typedef enum logic [2:0] {
		OK_RX       = 3'd0,
		OK_CMD      = 3'd1,
		OK_SB_BEGIN = 3'd2,
		OK_SB_DATA  = 3'd3,
		OK_SB_END   = 3'd4,
		OK_SB_ABORT = 3'd5,
		OK_TX       = 3'd6,
		OK_OPT_EN   = 3'd7
	} out_kind_t;

	typedef enum logic [2:0] {
		PS_NORMAL  = 3'd0,
		PS_IAC     = 3'd1,
		PS_OPT     = 3'd2,
		PS_CR      = 3'd3,
		PS_SB_OPT  = 3'd4,
		PS_SB_DATA = 3'd5,
		PS_SB_IAC  = 3'd6
	} parse_state_t;

	typedef enum logic [1:0] {
		TOP_NONE   = 2'd0,
		TOP_NEG    = 2'd1,
		TOP_LREQ   = 2'd2,
		TOP_POLICY = 2'd3
	} table_op_t;

	typedef struct packed {
		logic [1:0] rs;
		logic [1:0] want;
		logic       cur;
	} opt_entry_t;

	typedef struct packed {
		out_kind_t  kind;
		logic [7:0] data;
		logic       side;
	} event_t;

	// decoded request handed from the parser to the table stage
	typedef struct packed {
		table_op_t    op;
		logic         side;
		logic [7:0]   opt;
		logic         en;
		logic [1:0]   pol;
		logic [1:0]   n_ev;
		event_t [2:0] ev;
	} dec_t;

	function automatic logic opt_in_range(input logic [7:0] o);
		return 9'(o) < 9'(OPTION_COUNT);
	endfunction

	function automatic logic [TABLE_AW-1:0] table_addr(input logic side, input logic [7:0] o);
		return side ? TABLE_AW'(OPTION_COUNT) + TABLE_AW'(o) : TABLE_AW'(o);
	endfunction

	function automatic event_t mk_ev(input out_kind_t k, input logic [7:0] d, input logic s);
		event_t e;
		e.kind = k;
		e.data = d;
		e.side = s;
		return e;
	endfunction

endpackage

[hdl/tse_ram.sv]
// ----------------------------------------------------------------------------
// tse_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/tse_parse.sv]
// ----------------------------------------------------------------------------
// tse_parse
// Receive state machine and transmit escaping; turns each request into
// direct events or a table operation.
// ----------------------------------------------------------------------------
module tse_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  tse_pkg::in_kind_t  kind,
	input  logic [7:0]         byte_value,
	input  logic [7:0]         option_code,
	input  logic               local_side,
	input  logic               enable,
	input  logic [1:0]         want_policy,
	output tse_pkg::dec_t      dec
);

	typedef struct packed {
		logic [1:0]      n;
		tse_pkg::event_t e1;
		tse_pkg::event_t e0;
	} ev_pair_t;

	tse_pkg::parse_state_t state_q, state_d;
	logic [3:0]            pending_q, pending_d;
	logic [7:0]            cur_opt_q, cur_opt_d;
	logic [7:0]            cmd;
	ev_pair_t              nrm_r, iac_r;

	function automatic tse_pkg::parse_state_t normal_next(input logic [7:0] c);
		if (c == tse_pkg::B_CR) begin
			return tse_pkg::PS_CR;
		end else if (c == tse_pkg::B_IAC) begin
			return tse_pkg::PS_IAC;
		end
		return tse_pkg::PS_NORMAL;
	endfunction

	function automatic tse_pkg::parse_state_t iac_next(input logic [7:0] c);
		if (c == tse_pkg::C_SB) begin
			return tse_pkg::PS_SB_OPT;
		end else if (c inside {[tse_pkg::C_WILL:tse_pkg::C_DONT]}) begin
			return tse_pkg::PS_OPT;
		end else if (c < tse_pkg::C_SE) begin
			return normal_next(c);
		end
		return tse_pkg::PS_NORMAL;
	endfunction

	function automatic ev_pair_t normal_events(input logic [7:0] c);
		ev_pair_t r;
		r = '0;
		if (c != tse_pkg::B_CR && c != tse_pkg::B_IAC) begin
			r.n  = 2'd1;
			r.e0 = tse_pkg::mk_ev(tse_pkg::OK_RX, c, 1'b0);
		end
		return r;
	endfunction

	function automatic ev_pair_t iac_events(input logic [7:0] c);
		ev_pair_t r;
		ev_pair_t nr;
		r  = '0;
		nr = normal_events(c);
		if (c inside {[tse_pkg::C_CMD_LO:tse_pkg::C_CMD_HI]}) begin
			r.n  = 2'd1;
			r.e0 = tse_pkg::mk_ev(tse_pkg::OK_CMD, c, 1'b0);
		end else if (c == tse_pkg::B_IAC) begin
			r.n  = 2'd1;
			r.e0 = tse_pkg::mk_ev(tse_pkg::OK_RX, tse_pkg::B_IAC, 1'b0);
		end else if (c < tse_pkg::C_SE) begin
			// unknown command: literal iac, then the byte as plain data
			r.n  = 2'd1 + nr.n;
			r.e0 = tse_pkg::mk_ev(tse_pkg::OK_RX, tse_pkg::B_IAC, 1'b0);
			r.e1 = nr.e0;
		end
		return r;
	endfunction

	function automatic logic iac_sets_pending(input logic [7:0] c);
		return (c == tse_pkg::C_SB) || (c inside {[tse_pkg::C_WILL:tse_pkg::C_DONT]});
	endfunction

	assign cmd   = {4'hF, pending_q};
	assign nrm_r = normal_events(byte_value);
	assign iac_r = iac_events(byte_value);

	// next state
	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		cur_opt_d = cur_opt_q;
		if (kind == tse_pkg::IK_RX) begin
			case (state_q)
				tse_pkg::PS_IAC: begin
					state_d = iac_next(byte_value);
					if (iac_sets_pending(byte_value)) begin
						pending_d = byte_value[3:0];
					end
				end
				tse_pkg::PS_OPT: begin
					cur_opt_d = byte_value;
					state_d   = tse_pkg::PS_NORMAL;
				end
				tse_pkg::PS_CR: begin
					if (byte_value == tse_pkg::B_NUL || byte_value == tse_pkg::B_LF) begin
						state_d = tse_pkg::PS_NORMAL;
					end else begin
						state_d = normal_next(byte_value);
					end
				end
				tse_pkg::PS_SB_OPT: begin
					cur_opt_d = byte_value;
					state_d   = tse_pkg::PS_SB_DATA;
				end
				tse_pkg::PS_SB_DATA: begin
					state_d = (byte_value == tse_pkg::B_IAC) ? tse_pkg::PS_SB_IAC
						: tse_pkg::PS_SB_DATA;
				end
				tse_pkg::PS_SB_IAC: begin
					if (byte_value == tse_pkg::B_IAC) begin
						state_d = tse_pkg::PS_SB_DATA;
					end else if (byte_value == tse_pkg::C_SE) begin
						state_d = tse_pkg::PS_NORMAL;
					end else begin
						state_d = iac_next(byte_value);
						if (iac_sets_pending(byte_value)) begin
							pending_d = byte_value[3:0];
						end
					end
				end
				default: begin
					state_d = normal_next(byte_value);
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		dec = '0;
		case (kind)
			tse_pkg::IK_RX: begin
				case (state_q)
					tse_pkg::PS_IAC: begin
						dec.n_ev  = iac_r.n;
						dec.ev[0] = iac_r.e0;
						dec.ev[1] = iac_r.e1;
					end
					tse_pkg::PS_OPT: begin
						if (cmd inside {[tse_pkg::C_WILL:tse_pkg::C_DONT]}) begin
							dec.op   = tse_pkg::TOP_NEG;
							dec.side = (cmd == tse_pkg::C_DO) || (cmd == tse_pkg::C_DONT);
							dec.en   = (cmd == tse_pkg::C_WILL) || (cmd == tse_pkg::C_DO);
							dec.opt  = byte_value;
						end
					end
					tse_pkg::PS_CR: begin
						if (byte_value == tse_pkg::B_NUL) begin
							dec.n_ev  = 2'd1;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_RX, tse_pkg::B_CR, 1'b0);
						end else if (byte_value == tse_pkg::B_LF) begin
							dec.n_ev  = 2'd1;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_RX, tse_pkg::B_LF, 1'b0);
						end else begin
							dec.n_ev  = 2'd1 + nrm_r.n;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_RX, tse_pkg::B_CR, 1'b0);
							dec.ev[1] = nrm_r.e0;
						end
					end
					tse_pkg::PS_SB_OPT: begin
						dec.n_ev  = 2'd1;
						dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_SB_BEGIN, byte_value, 1'b0);
					end
					tse_pkg::PS_SB_DATA: begin
						if (byte_value != tse_pkg::B_IAC) begin
							dec.n_ev  = 2'd1;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_SB_DATA, byte_value, 1'b0);
						end
					end
					tse_pkg::PS_SB_IAC: begin
						if (byte_value == tse_pkg::B_IAC) begin
							dec.n_ev  = 2'd1;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_SB_DATA, tse_pkg::B_IAC, 1'b0);
						end else if (byte_value == tse_pkg::C_SE) begin
							dec.n_ev  = 2'd1;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_SB_END, cur_opt_q, 1'b0);
						end else begin
							// interrupted subnegotiation, byte reparsed as a command
							dec.n_ev  = 2'd1 + iac_r.n;
							dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_SB_ABORT, cur_opt_q, 1'b0);
							dec.ev[1] = iac_r.e0;
							dec.ev[2] = iac_r.e1;
						end
					end
					default: begin
						dec.n_ev  = nrm_r.n;
						dec.ev[0] = nrm_r.e0;
					end
				endcase
			end
			tse_pkg::IK_TX: begin
				dec.n_ev = 2'd2;
				if (byte_value == tse_pkg::B_CR) begin
					dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_CR, 1'b0);
					dec.ev[1] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_NUL, 1'b0);
				end else if (byte_value == tse_pkg::B_LF) begin
					dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_CR, 1'b0);
					dec.ev[1] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_LF, 1'b0);
				end else if (byte_value == tse_pkg::B_IAC) begin
					dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_IAC, 1'b0);
					dec.ev[1] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_IAC, 1'b0);
				end else begin
					dec.n_ev  = 2'd1;
					dec.ev[0] = tse_pkg::mk_ev(tse_pkg::OK_TX, byte_value, 1'b0);
				end
			end
			tse_pkg::IK_LREQ: begin
				if (tse_pkg::opt_in_range(option_code)) begin
					dec.op   = tse_pkg::TOP_LREQ;
					dec.side = local_side;
					dec.opt  = option_code;
					dec.en   = enable;
				end
			end
			tse_pkg::IK_POLICY: begin
				if (tse_pkg::opt_in_range(option_code) && want_policy != tse_pkg::POLICY_BAD) begin
					dec.op   = tse_pkg::TOP_POLICY;
					dec.side = local_side;
					dec.opt  = option_code;
					dec.pol  = want_policy;
				end
			end
			default: begin
				dec = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tse_pkg::PS_NORMAL;
			cur_opt_q <= '0;
		end else if (accept) begin
			state_q   <= state_d;
			cur_opt_q <= cur_opt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pending_q <= pending_d;
		end
	end

endmodule

[hdl/tse_option.sv]
// ----------------------------------------------------------------------------
// tse_option
// Option table update: negotiation replies, local requests and want policy;
// builds the result list of one request.
// ----------------------------------------------------------------------------
module tse_option (
	input  tse_pkg::dec_t           dec,
	input  tse_pkg::opt_entry_t     entry,
	output logic                    we,
	output tse_pkg::opt_entry_t     wdata,
	output logic [2:0]              n_res,
	output tse_pkg::event_t [3:0]   res
);

	tse_pkg::opt_entry_t ent;
	logic                opt_ok;
	logic                cur;
	logic [1:0]          rs;
	logic                act;
	logic                send;
	logic                agree;

	function automatic logic [7:0] reply_code(input logic side, input logic yes);
		if (side) begin
			return yes ? tse_pkg::C_WILL : tse_pkg::C_WONT;
		end
		return yes ? tse_pkg::C_DO : tse_pkg::C_DONT;
	endfunction

	assign opt_ok = tse_pkg::opt_in_range(dec.opt);

	always_comb begin
		// out of range options behave as an entry stuck at reset
		ent   = opt_ok ? entry : '0;
		cur   = ent.cur;
		rs    = ent.rs;
		act   = 1'b0;
		send  = 1'b0;
		agree = 1'b0;
		we    = 1'b0;
		wdata = ent;
		n_res = '0;
		res   = '0;
		case (dec.op)
			tse_pkg::TOP_NEG: begin
				if (rs == tse_pkg::RS_SENT) begin
					// answer to our own request
					rs  = tse_pkg::RS_ACK;
					cur = dec.en;
					act = 1'b1;
				end else if (dec.en != cur) begin
					act   = 1'b1;
					send  = 1'b1;
					agree = dec.en;
					if (!dec.en || ent.want == tse_pkg::WANT_WANTED
							|| ent.want == tse_pkg::WANT_ACCEPTED) begin
						rs  = tse_pkg::RS_ACK;
						cur = dec.en;
					end else begin
						agree = cur;
					end
				end
				if (send) begin
					res[0] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_IAC, 1'b0);
					res[1] = tse_pkg::mk_ev(tse_pkg::OK_TX, reply_code(dec.side, agree), 1'b0);
					res[2] = tse_pkg::mk_ev(tse_pkg::OK_TX, dec.opt, 1'b0);
					res[3] = tse_pkg::mk_ev(tse_pkg::OK_OPT_EN, dec.opt, dec.side);
					n_res  = cur ? 3'd4 : 3'd3;
				end else begin
					res[0] = tse_pkg::mk_ev(tse_pkg::OK_OPT_EN, dec.opt, dec.side);
					n_res  = (act && cur) ? 3'd1 : 3'd0;
				end
				we    = act && opt_ok;
				wdata = '{rs: rs, want: ent.want, cur: cur};
			end
			tse_pkg::TOP_LREQ: begin
				if (dec.en != cur) begin
					res[0] = tse_pkg::mk_ev(tse_pkg::OK_TX, tse_pkg::B_IAC, 1'b0);
					res[1] = tse_pkg::mk_ev(tse_pkg::OK_TX, reply_code(dec.side, dec.en), 1'b0);
					res[2] = tse_pkg::mk_ev(tse_pkg::OK_TX, dec.opt, 1'b0);
					n_res  = 3'd3;
					rs     = tse_pkg::RS_SENT;
				end
				we    = 1'b1;
				wdata = '{rs: rs, want: {1'b0, dec.en}, cur: cur};
			end
			tse_pkg::TOP_POLICY: begin
				we    = 1'b1;
				wdata = '{rs: ent.rs, want: dec.pol, cur: ent.cur};
			end
			default: begin
				n_res    = {1'b0, dec.n_ev};
				res[2:0] = dec.ev;
			end
		endcase
	end

endmodule

[hdl/tse_emit.sv]
// ----------------------------------------------------------------------------
// tse_emit
// Output stage: holds the result list of one request and sends it one
// result per cycle while m_axis_tready is high, marking the final one.
// ----------------------------------------------------------------------------
module tse_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [2:0]             n_res,
	input  tse_pkg::event_t [3:0]  res,
	output logic                   free,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata,   // [7:0] out_byte, [8] out_local
	output logic [2:0]             m_axis_tuser,   // [2:0] out_kind
	output logic                   m_axis_tlast
);

	tse_pkg::event_t [3:0] grp_q;
	logic                  valid_q;
	logic [1:0]            idx_q;
	logic [1:0]            last_idx_q;
	tse_pkg::event_t       cur_ev;
	logic                  done;

	assign cur_ev        = grp_q[idx_q];
	assign done          = m_axis_tvalid && m_axis_tready && m_axis_tlast;
	assign free          = !valid_q || done;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {7'b0, cur_ev.side, cur_ev.data};
	assign m_axis_tuser  = cur_ev.kind;
	assign m_axis_tlast  = idx_q == last_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (load) begin
			valid_q    <= 1'b1;
			idx_q      <= '0;
			last_idx_q <= 2'(n_res - 3'd1);
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result list loaded over one still being sent");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q <= last_idx_q)
		else $error("result index ran past the final result");
`endif

endmodule

[hdl/telnet_stream_endpoint_unit.sv]
// ----------------------------------------------------------------------------
// telnet_stream_endpoint_unit
// A taken request is registered into stage one, which reads and updates the
// option table; its results are then registered into the output stage.
// Throughput: one request per cycle unless a busy output stage stalls;
// results leave one per cycle while m_axis_tready is high; one option table
// read and write-back per request, with write forwarding. Reset: a clearing
// pass sweeps the option table; s_axis_tready stays low until it ends.
// ----------------------------------------------------------------------------
module telnet_stream_endpoint_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [7:0] byte_value, [15:8] option_code,
	                                    // [16] local_side, [17] enable, [19:18] want_policy
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] out_local
	output logic [2:0]  m_axis_tuser,   // [2:0] out_kind
	output logic        m_axis_tlast
);

	logic                            accept;
	tse_pkg::dec_t                   dec;
	logic [tse_pkg::TABLE_AW-1:0]    dec_addr;

	logic                            s1_valid_q;
	tse_pkg::dec_t                   dec_s1;
	logic [tse_pkg::TABLE_AW-1:0]    addr_s1;
	logic                            fwd_s1;
	tse_pkg::opt_entry_t             fwd_data_s1;

	logic                            clr_q;
	logic [tse_pkg::TABLE_AW-1:0]    clr_addr_q;

	logic [$bits(tse_pkg::opt_entry_t)-1:0] ram_rdata;
	logic                            ram_we;
	logic [tse_pkg::TABLE_AW-1:0]    ram_waddr;
	tse_pkg::opt_entry_t             ram_wdata;

	tse_pkg::opt_entry_t             entry_s1;
	logic                            s1_we;
	tse_pkg::opt_entry_t             s1_wdata;
	logic [2:0]                      n_res;
	tse_pkg::event_t [3:0]           res;
	logic                            emit_free;
	logic                            s1_adv;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s1_adv        = s1_valid_q && (n_res == 3'd0 || emit_free);
	assign s_axis_tready = !clr_q && (!s1_valid_q || s1_adv);
	assign dec_addr      = tse_pkg::table_addr(dec.side, dec.opt);
	assign entry_s1      = fwd_s1 ? fwd_data_s1 : tse_pkg::opt_entry_t'(ram_rdata);

	assign ram_we    = clr_q || (s1_adv && s1_we);
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? tse_pkg::opt_entry_t'('0) : s1_wdata;

	tse_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (tse_pkg::in_kind_t'(s_axis_tuser)),
		.byte_value  (s_axis_tdata[7:0]),
		.option_code (s_axis_tdata[15:8]),
		.local_side  (s_axis_tdata[16]),
		.enable      (s_axis_tdata[17]),
		.want_policy (s_axis_tdata[19:18]),
		.dec         (dec)
	);

	tse_ram #(
		.WIDTH ($bits(tse_pkg::opt_entry_t)),
		.DEPTH (tse_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (dec_addr),
		.rdata (ram_rdata)
	);

	tse_option u_option (
		.dec   (dec_s1),
		.entry (entry_s1),
		.we    (s1_we),
		.wdata (s1_wdata),
		.n_res (n_res),
		.res   (res)
	);

	tse_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s1_adv && n_res != 3'd0),
		.n_res         (n_res),
		.res           (res),
		.free          (emit_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			// write-back of the leaving request lands on the entry being read
			fwd_s1     <= s1_adv && s1_we && addr_s1 == dec_addr;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1      <= dec;
			addr_s1     <= dec_addr;
			fwd_data_s1 <= s1_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + tse_pkg::TABLE_AW'(1);
			if (clr_addr_q == tse_pkg::TABLE_AW'(tse_pkg::TABLE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_s1_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |-> !accept)
		else $error("request taken while stage one is stalled");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s1_valid_q)
		else $error("request in flight during the table clearing pass");

	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_addr_q) == tse_pkg::TABLE_AW'(tse_pkg::TABLE_DEPTH - 1))
		else $error("clearing pass ended before the last table entry");
`endif

endmodule
